// File: rtl/mtwg_pkg.sv
// mtwg_pkg: constants, types and word functions of the MT19937 word generator.
// No dependencies; used by mtwg_table_ram and mt19937_word_generator.
`default_nettype none

package mtwg_pkg;

    localparam int unsigned MtWords = 624;
    localparam int unsigned MtShift = 397;
    localparam int unsigned IdxW    = 10;

    localparam logic [31:0] InitMult = 32'd1812433253;
    localparam logic [31:0] Matrix   = 32'h9908_b0df;
    localparam logic [31:0] UpperMsk = 32'h8000_0000;
    localparam logic [31:0] LowerMsk = 32'h7fff_ffff;
    localparam logic [31:0] TemperB  = 32'h9d2c_5680;
    localparam logic [31:0] TemperC  = 32'hefc6_0000;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(MtWords - 1);
    localparam logic [IdxW-1:0] FarFwd  = IdxW'(MtShift);
    localparam logic [IdxW-1:0] FarBack = IdxW'(MtWords - MtShift);

    localparam logic REG_SEED = 1'b0;

    typedef logic [IdxW-1:0] idx_t;

    typedef struct packed {
        logic        we;
        idx_t        waddr;
        logic        re_a;
        idx_t        raddr_a;
        logic        re_b;
        idx_t        raddr_b;
    } ram_req_t;

    function automatic logic [31:0] seed_step(logic [31:0] prev, idx_t idx);
        logic [31:0] prod;
        prod = 32'(InitMult * (prev ^ (prev >> 30)));
        return prod + 32'(idx);
    endfunction

    function automatic logic [31:0] mix_pair(logic [31:0] hi_word, logic [31:0] lo_word,
                                             logic [31:0] far_word);
        logic [31:0] y;
        y = (hi_word & UpperMsk) | (lo_word & LowerMsk);
        return far_word ^ (y >> 1) ^ (y[0] ? Matrix : 32'd0);
    endfunction

    function automatic logic [31:0] temper(logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mt19937_word_generator.sv
// mt19937_word_generator: top level of the MT19937 tempered word source.
// Depends on mtwg_pkg and mtwg_table_ram.
`default_nettype none

// Each transfer on the s side yields one tempered 32-bit word on the m side. The
// table is twisted one word per draw, and a draw holds the block while its states
// run: the accepting cycle reads the current and next word, S_FAR reads the word
// 397 ahead, and S_MIX mixes and loads the output register once that register is
// free, waiting while the output is stalled; s_tready is high again after that.
// A transfer with restart set reseeds the table, one entry per cycle, before its
// reads start. After reset the table is seeded from seed = 0, while s_tready stays
// low; APB writes are taken at any time. The result waits in an output register, so
// a stalled m side holds at most one word.
module mt19937_word_generator
    import mtwg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] random_word
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEED = 5'b00010,
        S_READ = 5'b00100,
        S_FAR  = 5'b01000,
        S_MIX  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] seed_reg;
    idx_t        pos_reg, pos_next;
    idx_t        sidx_reg, sidx_next;
    logic [31:0] sval_reg, sval_next;
    logic        pend_reg, pend_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oword_reg, oword_next;

    ram_req_t    req;
    logic [31:0] wdata;
    logic [31:0] rdata_a;
    logic [31:0] rdata_b;

    logic        s_fire;
    logic        out_free;
    logic        cfg_wr;
    idx_t        pos_succ;
    idx_t        far_idx;
    logic [31:0] mixed;

    mtwg_table_ram u_ram (
        .clk     (clk),
        .req     (req),
        .wdata   (wdata),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_SEED);
    assign prdata   = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = oword_reg;
    assign out_free = !ovalid_reg || m_tready;

    assign pos_succ = (pos_reg == LastIdx) ? '0 : pos_reg + idx_t'(1);
    assign far_idx  = (pos_reg >= FarBack) ? pos_reg - FarBack : pos_reg + FarFwd;
    assign mixed    = mix_pair(hi_reg, lo_reg, rdata_a);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        sidx_next   = sidx_reg;
        sval_next   = sval_reg;
        pend_next   = pend_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oword_next  = oword_reg;
        req         = '0;
        wdata       = sval_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tdata[0])
                    begin
                        state_next = S_SEED;
                        sidx_next  = '0;
                        sval_next  = seed_reg;
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        req.re_a    = 1'b1;
                        req.raddr_a = pos_reg;
                        req.re_b    = 1'b1;
                        req.raddr_b = pos_succ;
                        state_next  = S_FAR;
                    end
                end
            end
            S_SEED:
            begin
                req.we    = 1'b1;
                req.waddr = sidx_reg;
                sidx_next = sidx_reg + idx_t'(1);
                sval_next = seed_step(sval_reg, sidx_reg + idx_t'(1));
                if (sidx_reg == LastIdx)
                begin
                    pos_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                req.re_a    = 1'b1;
                req.raddr_a = pos_reg;
                req.re_b    = 1'b1;
                req.raddr_b = pos_succ;
                state_next  = S_FAR;
            end
            S_FAR:
            begin
                hi_next     = rdata_a;
                lo_next     = rdata_b;
                req.re_a    = 1'b1;
                req.raddr_a = far_idx;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                if (out_free)
                begin
                    req.we      = 1'b1;
                    req.waddr   = pos_reg;
                    wdata       = mixed;
                    oword_next  = temper(mixed);
                    ovalid_next = 1'b1;
                    pos_next    = pos_succ;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SEED;
            seed_reg   <= 32'd0;
            pos_reg    <= '0;
            sidx_reg   <= '0;
            sval_reg   <= 32'd0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            sidx_reg   <= sidx_next;
            sval_reg   <= sval_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr)
            begin
                seed_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        oword_reg <= oword_next;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LastIdx)
        else $error("read position out of range");

    a_restart_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tdata[0]) |=> (state_reg == S_SEED) && (sidx_reg == '0))
        else $error("restart did not start seeding");

    a_mix_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && ovalid_reg && !m_tready) |=> (state_reg == S_MIX))
        else $error("result dropped while output slot full");

    a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEED && sidx_reg == LastIdx) |=> (pos_reg == '0))
        else $error("read position not cleared after seeding");
`endif

endmodule

`default_nettype wire

// File: rtl/mtwg_table_ram.sv
// mtwg_table_ram: 624 x 32 state table, one write port and two registered read ports.
// Depends on mtwg_pkg.
`default_nettype none

module mtwg_table_ram
    import mtwg_pkg::*;
(
    input  wire logic        clk,
    input  wire ram_req_t    req,
    input  wire logic [31:0] wdata,
    output logic      [31:0] rdata_a,
    output logic      [31:0] rdata_b
);

    logic [31:0] mem [0:MtWords-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= wdata;
        end
        if (req.re_a)
        begin
            rdata_a <= mem[req.raddr_a];
        end
        if (req.re_b)
        begin
            rdata_b <= mem[req.raddr_b];
        end
    end

endmodule

`default_nettype wire
